>>> design/websocket_frame_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// websocket deframer assertion macros
// shared concurrent assertion forms for the deframer checker
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wsdf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WSDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wsdf assertion failed");

`endif

>>> design/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// types and constants shared by the websocket deframer modules
// ----------------------------------------------------------------------------
package wsdf_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    // 7-bit length codes that select an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // index of the final byte in each multi-byte header field
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    // one result request
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_of_frame;
        logic       empty_frame;
        logic [3:0] frame_opcode;
        logic       fin_flag;
        logic [2:0] rsv_bits;
        logic       was_masked;
    } t_result;

endpackage

>>> design/wsdf_parser.sv
// ----------------------------------------------------------------------------
// wsdf_parser
// header/length/key state machine and payload unmasking, one byte per cycle while i_accept is high
// ----------------------------------------------------------------------------
module wsdf_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_res_push,
    output wsdf_pkg::t_result o_res
);
    import wsdf_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_field_index, n_field_index;
    logic [7:0]  r_first_header, n_first_header;
    logic        r_mask_present, n_mask_present;
    logic [63:0] r_remaining, n_remaining;
    logic [31:0] r_mask_key, n_mask_key;
    logic [1:0]  r_key_pos, n_key_pos;

    logic        after_len;
    logic        hdr_done;
    logic        res_valid;
    logic [7:0]  key_byte;
    logic [63:0] shifted_len;

    assign shifted_len = {r_remaining[55:0], i_byte};

    always_comb begin
        unique case (r_key_pos)
            2'd0: key_byte = r_mask_key[31:24];
            2'd1: key_byte = r_mask_key[23:16];
            2'd2: key_byte = r_mask_key[15:8];
            2'd3: key_byte = r_mask_key[7:0];
            default: key_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_field_index  = r_field_index;
        n_first_header = r_first_header;
        n_mask_present = r_mask_present;
        n_remaining    = r_remaining;
        n_mask_key     = r_mask_key;
        n_key_pos      = r_key_pos;
        after_len      = 1'b0;
        hdr_done       = 1'b0;
        res_valid      = 1'b0;
        o_res.payload_byte  = 8'd0;
        o_res.last_of_frame = 1'b0;
        o_res.empty_frame   = 1'b0;

        unique case (r_phase)
            PH_HDR0: begin
                n_first_header = i_byte;
                n_phase        = PH_HDR1;
            end
            PH_HDR1: begin
                n_mask_present = i_byte[7];
                n_remaining    = 64'd0;
                n_mask_key     = 32'd0;
                n_field_index  = 3'd0;
                if (i_byte[6:0] == LEN_CODE_16) begin
                    n_phase = PH_EXT16;
                end else if (i_byte[6:0] == LEN_CODE_64) begin
                    n_phase = PH_EXT64;
                end else begin
                    n_remaining = {57'd0, i_byte[6:0]};
                    after_len   = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_remaining = shifted_len;
                if ((r_phase == PH_EXT16 && r_field_index >= EXT16_LAST) ||
                    (r_phase == PH_EXT64 && r_field_index >= EXT64_LAST)) begin
                    after_len = 1'b1;
                end else begin
                    n_field_index = r_field_index + 3'd1;
                end
            end
            PH_KEY: begin
                n_mask_key = {r_mask_key[23:0], i_byte};
                if (r_field_index >= KEY_LAST) begin
                    hdr_done = 1'b1;
                end else begin
                    n_field_index = r_field_index + 3'd1;
                end
            end
            PH_PAYLOAD: begin
                res_valid          = 1'b1;
                o_res.payload_byte = r_mask_present ? (i_byte ^ key_byte) : i_byte;
                n_key_pos          = r_key_pos + 2'd1;
                n_remaining        = r_remaining - 64'd1;
                if (n_remaining == 64'd0) begin
                    o_res.last_of_frame = 1'b1;
                    n_phase             = PH_HDR0;
                end
            end
            default: begin
                n_phase = PH_HDR0;
            end
        endcase

        // length complete: key next if masked, else header is done
        if (after_len) begin
            n_field_index = 3'd0;
            if (n_mask_present) begin
                n_phase = PH_KEY;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            n_field_index = 3'd0;
            n_key_pos     = 2'd0;
            if (n_remaining == 64'd0) begin
                res_valid           = 1'b1;
                o_res.last_of_frame = 1'b1;
                o_res.empty_frame   = 1'b1;
                n_phase             = PH_HDR0;
            end else begin
                n_phase = PH_PAYLOAD;
            end
        end

        o_res.frame_opcode = n_first_header[3:0];
        o_res.fin_flag     = n_first_header[7];
        o_res.rsv_bits     = n_first_header[6:4];
        o_res.was_masked   = n_mask_present;
    end

    assign o_res_push = i_accept && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_field_index  <= 3'd0;
            r_first_header <= 8'd0;
            r_mask_present <= 1'b0;
            r_remaining    <= 64'd0;
            r_mask_key     <= 32'd0;
            r_key_pos      <= 2'd0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_field_index  <= n_field_index;
            r_first_header <= n_first_header;
            r_mask_present <= n_mask_present;
            r_remaining    <= n_remaining;
            r_mask_key     <= n_mask_key;
            r_key_pos      <= n_key_pos;
        end
    end

endmodule

>>> design/wsdf_out_reg.sv
// ----------------------------------------------------------------------------
// wsdf_out_reg
// result register with valid/ready toward the downstream side
// ----------------------------------------------------------------------------
module wsdf_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsdf_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output logic              o_room,
    output wsdf_pkg::t_result o_res
);
    import wsdf_pkg::*;

    logic    r_valid;
    t_result r_res;

    // room when empty or when the held request leaves this cycle
    assign o_room  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_push) begin
            r_res <= i_res;
        end
    end

endmodule

>>> design/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// splits a websocket frame byte stream into unmasked payload byte requests
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | payload
//  frame   | in        | i_frame_valid / o_frame_ready | i_frame_byte
//  result  | out       | o_res_valid / i_res_ready     | o_payload_byte .. o_was_masked
//
//  one byte accepted per cycle when the result side keeps up
//  a result is registered and appears in the cycle after the byte that causes it
//  rate is set by the single-pass parser feeding one result register
//  a stalled result blocks input only while it is held and not taken
//  synchronous active-low reset returns the parser to header byte 0
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // frame byte request
    input  logic       i_frame_valid,
    output logic       o_frame_ready,
    input  logic [7:0] i_frame_byte,
    // result request
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_last_of_frame,
    output logic       o_empty_frame,
    output logic [3:0] o_frame_opcode,
    output logic       o_fin_flag,
    output logic [2:0] o_rsv_bits,
    output logic       o_was_masked
);
    import wsdf_pkg::*;

    logic    frame_accept;
    logic    res_push;
    logic    out_room;
    t_result parse_res;
    t_result held_res;

    // a byte is taken whenever the result register can absorb its outcome
    assign o_frame_ready = out_room;
    assign frame_accept  = i_frame_valid && out_room;

    // header, length, key and payload phases
    wsdf_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (frame_accept),
        .i_byte     (i_frame_byte),
        .o_res_push (res_push),
        .o_res      (parse_res)
    );

    // result register decouples the downstream stall from the parser
    wsdf_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (parse_res),
        .i_ready (i_res_ready),
        .o_valid (o_res_valid),
        .o_room  (out_room),
        .o_res   (held_res)
    );

    // fan the held result out to its ports
    assign o_payload_byte  = held_res.payload_byte;
    assign o_last_of_frame = held_res.last_of_frame;
    assign o_empty_frame   = held_res.empty_frame;
    assign o_frame_opcode  = held_res.frame_opcode;
    assign o_fin_flag      = held_res.fin_flag;
    assign o_rsv_bits      = held_res.rsv_bits;
    assign o_was_masked    = held_res.was_masked;

endmodule

>>> design/wsdf_checker.sv
// ----------------------------------------------------------------------------
// wsdf_checker
// port-level checks on the websocket deframer, bound to the top level
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_core_macros.svh"

module wsdf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_frame_valid,
    input logic       o_frame_ready,
    input logic [7:0] i_frame_byte,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [7:0] o_payload_byte,
    input logic       o_last_of_frame,
    input logic       o_empty_frame,
    input logic [3:0] o_frame_opcode,
    input logic       o_fin_flag,
    input logic [2:0] o_rsv_bits,
    input logic       o_was_masked
);

    // held result stays put while stalled
    `WSDF_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n,
        o_res_valid && !i_res_ready,
        o_res_valid && $stable(o_payload_byte) && $stable(o_last_of_frame) &&
        $stable(o_empty_frame) && $stable(o_frame_opcode) && $stable(o_fin_flag) &&
        $stable(o_rsv_bits) && $stable(o_was_masked))

    // empty frame request carries last and a zero byte
    `WSDF_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, o_res_valid && o_empty_frame, o_last_of_frame && (o_payload_byte == 8'd0))

    // input stalls only behind a held, untaken result
    `WSDF_ASSERT_NOW(a_stall_only, i_clk, i_rst_n, !o_frame_ready, o_res_valid && !i_res_ready)

    // an empty result register always takes input
    `WSDF_ASSERT_NOW(a_ready_empty, i_clk, i_rst_n, !o_res_valid, o_frame_ready)

    // a waiting frame byte request holds its byte
    `WSDF_ASSERT_NEXT(a_frame_hold, i_clk, i_rst_n,
        i_frame_valid && !o_frame_ready,
        i_frame_valid && $stable(i_frame_byte))

endmodule

bind websocket_frame_deframer_core wsdf_checker u_wsdf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_frame_valid   (i_frame_valid),
    .o_frame_ready   (o_frame_ready),
    .i_frame_byte    (i_frame_byte),
    .o_res_valid     (o_res_valid),
    .i_res_ready     (i_res_ready),
    .o_payload_byte  (o_payload_byte),
    .o_last_of_frame (o_last_of_frame),
    .o_empty_frame   (o_empty_frame),
    .o_frame_opcode  (o_frame_opcode),
    .o_fin_flag      (o_fin_flag),
    .o_rsv_bits      (o_rsv_bits),
    .o_was_masked    (o_was_masked)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket frame deframer testbench
// drives frame byte streams with random gaps and result-side stalls, and
// checks each result request against a cycle-free parser model or a typed result
// ----------------------------------------------------------------------------
module testbench;
    import wsdf_pkg::*;

    // how a row of the directed stimulus is checked
    typedef enum logic [1:0] {
        ROW_QUIET   = 2'd0,   // header byte, no result may follow
        ROW_PREDICT = 2'd1,   // result taken from the parser model
        ROW_TYPED   = 2'd2    // result typed into the row itself
    } t_row_kind;

    typedef struct packed {
        logic [7:0] data;
        t_row_kind  kind;
        t_result    want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_frame_valid;
    logic       o_frame_ready;
    logic [7:0] i_frame_byte;
    logic       o_res_valid;
    logic       i_res_ready;
    logic [7:0] o_payload_byte;
    logic       o_last_of_frame;
    logic       o_empty_frame;
    logic [3:0] o_frame_opcode;
    logic       o_fin_flag;
    logic [2:0] o_rsv_bits;
    logic       o_was_masked;

    // parser model state
    t_phase      st_phase;
    logic [2:0]  st_index;
    logic [7:0]  st_hdr0;
    logic        st_masked;
    logic [63:0] st_remaining;
    logic [31:0] st_key;
    logic [1:0]  st_keypos;

    t_result   awaited_results[$];
    t_stim_row directed_rows[$];
    int        error_count = 0;
    int        bytes_sent  = 0;
    bit        idle_on     = 1'b1;
    bit        hold_request = 1'b0;
    bit        hold_taken   = 1'b0;
    int        ready_stall  = 0;

    websocket_frame_deframer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_valid   (i_frame_valid),
        .o_frame_ready   (o_frame_ready),
        .i_frame_byte    (i_frame_byte),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_payload_byte  (o_payload_byte),
        .o_last_of_frame (o_last_of_frame),
        .o_empty_frame   (o_empty_frame),
        .o_frame_opcode  (o_frame_opcode),
        .o_fin_flag      (o_fin_flag),
        .o_rsv_bits      (o_rsv_bits),
        .o_was_masked    (o_was_masked)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic t_result mk_result(input logic [7:0] pb, input logic last,
                                          input logic empty, input logic [3:0] op,
                                          input logic fin, input logic [2:0] rsv,
                                          input logic masked);
        t_result r;
        r.payload_byte  = pb;
        r.last_of_frame = last;
        r.empty_frame   = empty;
        r.frame_opcode  = op;
        r.fin_flag      = fin;
        r.rsv_bits      = rsv;
        r.was_masked    = masked;
        return r;
    endfunction

    // mostly back to back, often a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_error(input string msg);
        $display("error: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // append a result to the tail of the awaited list
    function automatic void await_result(input t_result r);
        awaited_results = {awaited_results, r};
    endfunction

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic void parser_reset();
        st_phase     = PH_HDR0;
        st_index     = '0;
        st_hdr0      = '0;
        st_masked    = 1'b0;
        st_remaining = '0;
        st_key       = '0;
        st_keypos    = '0;
    endfunction

    // header complete: zero length gives the empty-frame result right away
    function automatic bit close_header(output t_result r);
        r         = '0;
        st_index  = '0;
        st_keypos = '0;
        if (st_remaining == 64'd0) begin
            r = mk_result(8'h00, 1'b1, 1'b1, st_hdr0[3:0], st_hdr0[7],
                          st_hdr0[6:4], st_masked);
            st_phase = PH_HDR0;
            return 1'b1;
        end
        st_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // length known: a mask key comes next if the mask bit was set
    function automatic bit length_done(output t_result r);
        r        = '0;
        st_index = '0;
        if (st_masked) begin
            st_phase = PH_KEY;
            return 1'b0;
        end
        return close_header(r);
    endfunction

    // one raw byte through the parser; returns 1 if it yields a result
    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        logic [7:0] kb;
        logic [6:0] code;
        r = '0;
        case (st_phase)
            PH_HDR0: begin
                st_hdr0  = b;
                st_phase = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                st_masked    = b[7];
                code         = b[6:0];
                st_remaining = '0;
                st_key       = '0;
                st_index     = '0;
                if (code == LEN_CODE_16) begin
                    st_phase = PH_EXT16;
                    return 1'b0;
                end
                if (code == LEN_CODE_64) begin
                    st_phase = PH_EXT64;
                    return 1'b0;
                end
                st_remaining = {57'd0, code};
                return length_done(r);
            end
            PH_EXT16, PH_EXT64: begin
                // big-endian, non-minimal encodings taken as given
                st_remaining = {st_remaining[55:0], b};
                if ((st_phase == PH_EXT16 && st_index >= EXT16_LAST) ||
                    (st_phase == PH_EXT64 && st_index >= EXT64_LAST))
                    return length_done(r);
                st_index = st_index + 3'd1;
                return 1'b0;
            end
            PH_KEY: begin
                st_key = {st_key[23:0], b};
                if (st_index >= KEY_LAST)
                    return close_header(r);
                st_index = st_index + 3'd1;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                // key byte 0 sits in bits 31..24
                kb = st_masked ? st_key[8 * (3 - st_keypos) +: 8] : 8'h00;
                r  = mk_result(b ^ kb, st_remaining == 64'd1, 1'b0, st_hdr0[3:0],
                               st_hdr0[7], st_hdr0[6:4], st_masked);
                st_keypos    = st_keypos + 2'd1;
                st_remaining = st_remaining - 64'd1;
                if (st_remaining == 64'd0)
                    st_phase = PH_HDR0;
                return 1'b1;
            end
            default: begin
                st_phase = PH_HDR0;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // frame byte side
    // ------------------------------------------------------------------------
    // called at a rising edge; returns at the edge that takes the byte
    task automatic send_byte(input logic [7:0] b, input t_row_kind kind,
                             input t_result want);
        int      gap;
        t_result predicted;
        bit      has_result;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_frame_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_frame_valid <= 1'b1;
        i_frame_byte  <= b;
        do @(posedge i_clk); while (!o_frame_ready);
        bytes_sent++;
        has_result = deframe_byte(b, predicted);
        case (kind)
            ROW_TYPED:   await_result(want);
            ROW_PREDICT: if (has_result) await_result(predicted);
            default:     ;
        endcase
    endtask

    task automatic send_random(input logic [7:0] b);
        send_byte(b, ROW_PREDICT, '0);
    endtask

    // one well-formed frame with random header bits, length form and content
    task automatic send_random_frame();
        logic [7:0]  hdr0;
        logic        masked;
        logic [6:0]  code;
        logic [63:0] len;
        int          ext_bytes;
        int          r;
        hdr0   = 8'($urandom_range(0, 255));
        masked = 1'($urandom_range(0, 1));
        r      = $urandom_range(0, 99);
        ext_bytes = 0;
        if (r < 10) begin
            len = 64'd0;
        end else if (r < 60) begin
            len = 64'($urandom_range(1, 16));
        end else if (r < 75) begin
            len = 64'($urandom_range(17, 125));
        end else if (r < 90) begin
            // 16-bit form, mostly with a length that fits in seven bits
            len = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 400))
                                              : 64'($urandom_range(0, 40));
            ext_bytes = 2;
        end else begin
            len = 64'($urandom_range(0, 40));
            ext_bytes = 8;
        end
        if (ext_bytes == 2)      code = LEN_CODE_16;
        else if (ext_bytes == 8) code = LEN_CODE_64;
        else                     code = len[6:0];
        send_random(hdr0);
        send_random({masked, code});
        for (int i = ext_bytes - 1; i >= 0; i--)
            send_random(len[8 * i +: 8]);
        if (masked)
            repeat (4) send_random(8'($urandom_range(0, 255)));
        for (longint unsigned n = 0; n < len; n++)
            send_random(8'($urandom_range(0, 255)));
    endtask

    function automatic void add_row(input logic [7:0] data, input t_row_kind kind,
                                    input t_result want);
        t_stim_row row;
        row.data = data;
        row.kind = kind;
        row.want = want;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_quiet(input logic [7:0] data);
        add_row(data, ROW_QUIET, '0);
    endfunction

    function automatic void add_predicted(input logic [7:0] data);
        add_row(data, ROW_PREDICT, '0);
    endfunction

    function automatic void build_directed_rows();
        // empty unmasked text frame straight after reset
        add_quiet(8'h81);
        add_row(8'h00, ROW_TYPED, mk_result(8'h00, 1'b1, 1'b1, 4'h1, 1'b1, 3'd0, 1'b0));
        // all header bits set, one all-ones byte of payload
        add_quiet(8'hFF);
        add_quiet(8'h01);
        add_row(8'hFF, ROW_TYPED, mk_result(8'hFF, 1'b1, 1'b0, 4'hF, 1'b1, 3'd7, 1'b0));
        // masked, non-minimal 16-bit length of 5, key index wraps past 3
        add_quiet(8'h02);
        add_quiet(8'hFE);
        add_quiet(8'h00);
        add_quiet(8'h05);
        add_quiet(8'h00);
        add_quiet(8'hFF);
        add_quiet(8'hA5);
        add_quiet(8'h5A);
        add_predicted(8'hFF);
        add_predicted(8'h00);
        add_predicted(8'h3C);
        add_predicted(8'hC3);
        add_predicted(8'h81);
        // empty frame in the 64-bit form, reserved bits set, no fin
        add_quiet(8'h70);
        add_quiet(8'h7F);
        for (int i = 0; i < 7; i++)
            add_quiet(8'h00);
        add_row(8'h00, ROW_TYPED, mk_result(8'h00, 1'b1, 1'b1, 4'h0, 1'b0, 3'd7, 1'b0));
    endfunction

    // ------------------------------------------------------------------------
    // result side: random ready, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_taken  = 1'b1;
                ready_stall = 400;
            end
            if (ready_stall > 0) begin
                ready_stall--;
                i_res_ready <= 1'b0;
            end else if (!i_rst_n || !idle_on) begin
                i_res_ready <= 1'b1;
            end else begin
                ready_stall = pick_gap();
                if (ready_stall == 0) begin
                    i_res_ready <= 1'b1;
                end else begin
                    i_res_ready <= 1'b0;
                    ready_stall--;
                end
            end
        end
    end

    // every taken result against the oldest one awaited
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (awaited_results.size() == 0) begin
                flag_error("result request with nothing awaited");
            end else begin
                want = awaited_results.pop_front();
                check_field("payload_byte", o_payload_byte, want.payload_byte);
                check_field("last_of_frame", 8'(o_last_of_frame), 8'(want.last_of_frame));
                check_field("empty_frame", 8'(o_empty_frame), 8'(want.empty_frame));
                check_field("frame_opcode", 8'(o_frame_opcode), 8'(want.frame_opcode));
                check_field("fin_flag", 8'(o_fin_flag), 8'(want.fin_flag));
                check_field("rsv_bits", 8'(o_rsv_bits), 8'(want.rsv_bits));
                check_field("was_masked", 8'(o_was_masked), 8'(want.was_masked));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_frame_valid <= 1'b0;
        i_frame_byte  <= 8'h00;
        i_res_ready   <= 1'b0;
        parser_reset();
        build_directed_rows();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].kind, directed_rows[i].want);

        // random frames; some run with no idling on either side
        while (bytes_sent < 850) begin
            idle_on = ($urandom_range(0, 4) != 0);
            if (bytes_sent >= 400)
                hold_request = 1'b1;
            send_random_frame();
        end
        idle_on = 1'b1;

        // length with its top bit set never ends, so it closes the run
        send_random(8'($urandom_range(0, 255)));
        send_random(8'hFF);
        send_random(8'h80);
        repeat (7) send_random(8'($urandom_range(0, 255)));
        repeat (4) send_random(8'($urandom_range(0, 255)));
        repeat (24) send_random(8'($urandom_range(0, 255)));
        i_frame_valid <= 1'b0;

        // drain, then wait a while for anything unexpected
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // far beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/wsdf_pkg.sv
design/wsdf_parser.sv
design/wsdf_out_reg.sv
design/websocket_frame_deframer_core.sv
design/wsdf_checker.sv
tb/sv/testbench.sv
